// ----- src/lfr_pkg.sv -----
// ----------------------------------------------------------------------------
// lfr_pkg
// Shared constants and types for the line-editing receive FIFO.
// ----------------------------------------------------------------------------
package lfr_pkg;

  // default ring size in bytes
  localparam int DEPTH_DEFAULT = 64;

  typedef logic [7:0] byte_t;

  // request kinds
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // control characters
  localparam byte_t CH_CR  = 8'h0D;
  localparam byte_t CH_BS  = 8'h08;
  localparam byte_t CH_DEL = 8'h7F;

endpackage

// ----- src/lfr_if.sv -----
// ----------------------------------------------------------------------------
// lfr_in_if / lfr_out_if
// Valid/ready channels for requests into and line characters out of the FIFO.
// ----------------------------------------------------------------------------
interface lfr_in_if;
  logic          valid;
  logic          ready;
  logic          kind;
  lfr_pkg::byte_t rx_byte;

  modport source (output valid, output kind, output rx_byte, input ready);
  modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface

interface lfr_out_if;
  logic          valid;
  logic          ready;
  lfr_pkg::byte_t line_char;
  logic          got_line;
  logic          last;

  modport source (output valid, output line_char, output got_line, output last,
                  input ready);
  modport sink   (input valid, input line_char, input got_line, input last,
                  output ready);
endinterface

// ----- src/lfr_ram.sv -----
// ----------------------------------------------------------------------------
// lfr_ram
// Simple dual-port byte RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module lfr_ram #(
  parameter int DEPTH = lfr_pkg::DEPTH_DEFAULT,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic           clk,
  input  logic           we,
  input  logic [AW-1:0]  waddr,
  input  lfr_pkg::byte_t wdata,
  input  logic [AW-1:0]  raddr,
  output lfr_pkg::byte_t rdata
);

  lfr_pkg::byte_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- src/line_edit_receive_fifo_core.sv -----
// ----------------------------------------------------------------------------
// line_edit_receive_fifo_core
// Receive ring buffer that edits lines as bytes arrive and hands out lines.
// ----------------------------------------------------------------------------
// A received byte (kind 0) gives no result: a carriage return sets the
// line-ready flag and is stored, backspace or delete removes the newest
// stored byte, anything else is stored unless the ring (DEPTH-1 bytes
// usable) is full. A read-line request (kind 1) gives one result with
// got_line 0 and last 1 if no line is ready; otherwise it streams the
// stored bytes up to the carriage return, one per cycle while the output
// is not stalled, then a zero terminator with last set. The first result
// passes through the drain state, working on the word the ring RAM read
// out at the request, and then the output register. No new request is
// taken until a read has loaded its last result; received bytes are
// accepted whenever no read is in progress. Output stalls hold the stream
// without losing data.
module line_edit_receive_fifo_core #(
  parameter int DEPTH = lfr_pkg::DEPTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  lfr_in_if.sink           rx_req,
  lfr_out_if.source        line_out
);

  localparam int AW = $clog2(DEPTH);
  localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  logic           state, state_next;
  logic [AW-1:0]  write_ptr, write_ptr_next;
  logic [AW-1:0]  read_ptr, read_ptr_next;
  logic           line_ready, line_ready_next;

  logic [AW-1:0]  wp_inc, wp_dec, rp_inc;
  logic           ring_empty, ring_full;
  logic           req_xfer, out_free;
  logic           ram_we;
  lfr_pkg::byte_t rd_data;

  logic           out_load;
  lfr_pkg::byte_t out_char_next;
  logic           out_got_next, out_last_next;

  // pointer arithmetic with wrap at any depth
  assign wp_inc = (write_ptr == PTR_LAST) ? '0 : write_ptr + 1'b1;
  assign wp_dec = (write_ptr == '0) ? PTR_LAST : write_ptr - 1'b1;
  assign rp_inc = (read_ptr == PTR_LAST) ? '0 : read_ptr + 1'b1;

  assign ring_empty = (read_ptr == write_ptr);
  assign ring_full  = (wp_inc == read_ptr);

  assign rx_req.ready = (state == ST_IDLE);
  assign req_xfer     = rx_req.valid && rx_req.ready;
  assign out_free     = !line_out.valid || line_out.ready;

  // next-state logic for pointers, flag and output load
  always_comb begin
    state_next      = state;
    write_ptr_next  = write_ptr;
    read_ptr_next   = read_ptr;
    line_ready_next = line_ready;
    ram_we          = 1'b0;
    out_load        = 1'b0;
    out_char_next   = '0;
    out_got_next    = 1'b0;
    out_last_next   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (req_xfer) begin
          if (rx_req.kind == lfr_pkg::KIND_READ) begin
            state_next = ST_DRAIN;
          end else begin
            if (rx_req.rx_byte == lfr_pkg::CH_CR) begin
              line_ready_next = 1'b1;
            end
            if (!(rx_req.rx_byte inside {lfr_pkg::CH_BS, lfr_pkg::CH_DEL})) begin
              if (!ring_full) begin
                ram_we         = 1'b1;
                write_ptr_next = wp_inc;
              end
            end else if (!ring_empty) begin
              write_ptr_next = wp_dec;
            end
          end
        end
      end
      ST_DRAIN: begin
        if (out_free) begin
          out_load = 1'b1;
          if (!line_ready) begin
            out_last_next = 1'b1;
            state_next    = ST_IDLE;
          end else if (ring_empty) begin
            out_got_next    = 1'b1;
            out_last_next   = 1'b1;
            line_ready_next = 1'b0;
            state_next      = ST_IDLE;
          end else if (rd_data == lfr_pkg::CH_CR) begin
            // drop the carriage return and terminate
            read_ptr_next   = rp_inc;
            out_got_next    = 1'b1;
            out_last_next   = 1'b1;
            line_ready_next = 1'b0;
            state_next      = ST_IDLE;
          end else begin
            read_ptr_next = rp_inc;
            out_char_next = rd_data;
            out_got_next  = 1'b1;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      write_ptr  <= '0;
      read_ptr   <= '0;
      line_ready <= 1'b0;
    end else begin
      state      <= state_next;
      write_ptr  <= write_ptr_next;
      read_ptr   <= read_ptr_next;
      line_ready <= line_ready_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      line_out.valid <= 1'b0;
    end else if (out_load) begin
      line_out.valid <= 1'b1;
    end else if (line_out.ready) begin
      line_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      line_out.line_char <= out_char_next;
      line_out.got_line  <= out_got_next;
      line_out.last      <= out_last_next;
    end
  end

  // ring storage; read address tracks the upcoming read pointer
  lfr_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (write_ptr),
    .wdata (rx_req.rx_byte),
    .raddr (read_ptr_next),
    .rdata (rd_data)
  );

endmodule
